>>> rtl/core/calendar_date_difference_defines.svh
// ---------------------------------------------------------------------------
// calendar date difference assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_DIFFERENCE_DEFINES_SVH

// checked only outside reset
`define CDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define CDD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cdd_pkg.sv
// ---------------------------------------------------------------------------
// cdd_pkg
// widths, constants and the month length table for the date difference
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned EDAY_W  = 6;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 48;

  // floor(y / 25) == (y * RECIP_25) >> RECIP_SHIFT for every 14-bit y
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = 27;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [1:0] ORDER_BEFORE = 2'd0;
  localparam logic [1:0] ORDER_EQUAL  = 2'd1;
  localparam logic [1:0] ORDER_AFTER  = 2'd2;

  localparam logic [3:0] DECEMBER = 4'd12;
  localparam logic [3:0] MARCH    = 4'd3;

  localparam logic [DAY_W-1:0] MONTH_DAYS [13] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // length of the month before end month em: december for em 0 or 1, zero for em 14 or 15
  function automatic logic [DAY_W-1:0] borrow_len(input logic [MONTH_W-1:0] em,
                                                  input logic leap);
    logic [MONTH_W-1:0] bm;
    bm = em - 4'd1;
    if (em <= 4'd1) begin
      borrow_len = MONTH_DAYS[DECEMBER];
    end else if (bm > DECEMBER) begin
      borrow_len = '0;
    end else if (em == MARCH && leap) begin
      borrow_len = 5'd29;
    end else begin
      borrow_len = MONTH_DAYS[bm];
    end
  endfunction

endpackage

>>> rtl/core/calendar_date_difference.sv
// ---------------------------------------------------------------------------
// calendar_date_difference: three register stages with bubble collapse
// throughput one item per cycle unless m_tready stalls the output
// sync active-high rst clears all stage valid bits, no clearing pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_difference #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_year[13:0] start_month[17:14] start_day[22:18]
  // end_year[36:23] end_month[40:37] end_day[45:41], zero pad [47:46]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // order[1:0] elapsed_years[15:2] elapsed_months[19:16]
  // elapsed_days[25:20] total_months[42:26], zero pad [47:43]
  output logic [47:0] m_tdata
);

  localparam logic [16:0] MAXY = 17'(MAX_YEAR);

  logic en1, en2, en3;
  logic v1, v2, v3;

  // stage 1: input fields, years clamped to MAX_YEAR
  logic [13:0] s1_sy, s1_ey;
  logic [3:0]  s1_sm, s1_em;
  logic [4:0]  s1_sd, s1_ed;
  logic [13:0] sy_in, ey_in;

  // stage 2: differences, order, reciprocal product
  logic [14:0] dy;
  logic [4:0]  dm;
  logic [5:0]  dd;
  logic [1:0]  order_next;
  logic [18:0] dy_ext, tot_next;
  logic [1:0]  s2_order;
  logic        s2_ge, s2_borrow;
  logic [13:0] s2_dy, s2_ey;
  logic [4:0]  s2_dm;
  logic [5:0]  s2_dd;
  logic [3:0]  s2_em;
  logic [26:0] s2_prod;
  logic [18:0] s2_tot;

  // stage 3: result
  logic [9:0]  q25;
  logic [13:0] r25;
  logic        leap;
  logic [4:0]  blen;
  logic [5:0]  days_next, mraw;
  logic [3:0]  months_next;
  logic [13:0] years_next;
  logic [16:0] total_next;
  logic [1:0]  r_order;
  logic [13:0] r_years;
  logic [3:0]  r_months;
  logic [5:0]  r_days;
  logic [16:0] r_total;

  assign en3 = !v3 || m_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_comb begin
    sy_in = s_tdata[13:0];
    ey_in = s_tdata[36:23];
    if ({3'b0, sy_in} > MAXY) begin
      sy_in = MAXY[13:0];
    end
    if ({3'b0, ey_in} > MAXY) begin
      ey_in = MAXY[13:0];
    end
  end

  always_comb begin
    dy = {1'b0, s1_ey} - {1'b0, s1_sy};
    dm = {1'b0, s1_em} - {1'b0, s1_sm};
    dd = {1'b0, s1_ed} - {1'b0, s1_sd};
    if (dy != '0) begin
      order_next = dy[14] ? cdd_pkg::ORDER_BEFORE : cdd_pkg::ORDER_AFTER;
    end else if (dm != '0) begin
      order_next = dm[4] ? cdd_pkg::ORDER_BEFORE : cdd_pkg::ORDER_AFTER;
    end else if (dd != '0) begin
      order_next = dd[5] ? cdd_pkg::ORDER_BEFORE : cdd_pkg::ORDER_AFTER;
    end else begin
      order_next = cdd_pkg::ORDER_EQUAL;
    end
    // total before saturation: dy * 12 + dm - borrow
    dy_ext   = {{4{dy[14]}}, dy};
    tot_next = (dy_ext << 3) + (dy_ext << 2) + {{14{dm[4]}}, dm} - {18'b0, dd[5]};
  end

  always_comb begin
    q25  = s2_prod[cdd_pkg::RECIP_SHIFT +: 10];
    r25  = s2_ey - ({4'b0, q25} << 4) - ({4'b0, q25} << 3) - {4'b0, q25};
    // divisible by 4, and by 16 whenever divisible by 25 (century years)
    leap = (s2_ey[1:0] == 2'b00) && ((r25 != '0) || (s2_ey[3:0] == 4'b0000));
    blen = cdd_pkg::borrow_len(s2_em, leap);
    days_next   = s2_dd + (s2_borrow ? {1'b0, blen} : 6'd0);
    mraw        = {s2_dm[4], s2_dm} - {5'b0, s2_borrow};
    months_next = mraw[3:0] + (mraw[5] ? 4'd12 : 4'd0);
    years_next  = s2_dy - {13'b0, mraw[5]};
    if (s2_tot[18]) begin
      total_next = '0;
    end else if (s2_tot[17]) begin
      total_next = cdd_pkg::TOTAL_MAX;
    end else begin
      total_next = s2_tot[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      s1_sy <= sy_in;
      s1_sm <= s_tdata[17:14];
      s1_sd <= s_tdata[22:18];
      s1_ey <= ey_in;
      s1_em <= s_tdata[40:37];
      s1_ed <= s_tdata[45:41];
    end
    if (en2 && v1) begin
      s2_order  <= order_next;
      s2_ge     <= (order_next != cdd_pkg::ORDER_BEFORE);
      s2_borrow <= dd[5];
      s2_dy     <= dy[13:0];
      s2_dm     <= dm;
      s2_dd     <= dd;
      s2_em     <= s1_em;
      s2_ey     <= s1_ey;
      s2_prod   <= 27'(s1_ey) * 27'(cdd_pkg::RECIP_25);
      s2_tot    <= tot_next;
    end
    if (en3 && v2) begin
      r_order <= s2_order;
      if (s2_ge) begin
        r_years  <= years_next;
        r_months <= months_next;
        r_days   <= days_next;
        r_total  <= total_next;
      end else begin
        r_years  <= '0;
        r_months <= '0;
        r_days   <= '0;
        r_total  <= '0;
      end
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {5'b0, r_total, r_days, r_months, r_years, r_order};

endmodule

>>> rtl/core/cdd_checker.sv
// ---------------------------------------------------------------------------
// cdd_checker
// port-level checks on the date difference stream, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_date_difference_defines.svh"

module cdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic end_not_after;

  // end before or equal to start leaves no duration
  assign end_not_after = (m_tdata[1:0] != cdd_pkg::ORDER_AFTER);

  `CDD_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "output item valid after reset")

  `CDD_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

  `CDD_ASSERT(a_zero_duration, m_tvalid && end_not_after |-> m_tdata[42:2] == '0, "duration")

  `CDD_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "output item dropped")

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/calendar_date_difference_tb.sv
// ---------------------------------------------------------------------------
// calendar_date_difference_tb
// streams start/end date pairs into the block with random gaps on both sides
// and compares every difference item against an in-bench calendar predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_difference_tb;

  localparam int YEAR_LIMIT  = 9999;
  localparam int RAND_ITEMS  = 900;
  localparam int QUIET_START = 780;
  localparam int CYCLE_LIMIT = 200000;

  // start_year, start_month, start_day, end_year, end_month, end_day from bit 0
  typedef struct packed {
    logic [1:0]                  pad;
    logic [cdd_pkg::DAY_W-1:0]   end_day;
    logic [cdd_pkg::MONTH_W-1:0] end_month;
    logic [cdd_pkg::YEAR_W-1:0]  end_year;
    logic [cdd_pkg::DAY_W-1:0]   start_day;
    logic [cdd_pkg::MONTH_W-1:0] start_month;
    logic [cdd_pkg::YEAR_W-1:0]  start_year;
  } date_pair_t;

  // order, elapsed_years, elapsed_months, elapsed_days, total_months from bit 0
  typedef struct packed {
    logic [4:0]                  pad;
    logic [cdd_pkg::TOTAL_W-1:0] total_months;
    logic [cdd_pkg::EDAY_W-1:0]  elapsed_days;
    logic [cdd_pkg::MONTH_W-1:0] elapsed_months;
    logic [cdd_pkg::YEAR_W-1:0]  elapsed_years;
    logic [1:0]                  order;
  } date_diff_t;

  class date_diff_scoreboard;
    date_diff_t expected_diffs[$];
    int errors = 0;

    static function bit is_leap(int y);
      if (y < 0) y = -y;
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    static function int month_length(int y, int m);
      if (m < 1 || m > 12) return 0;
      if (m == 2 && is_leap(y)) return 29;
      case (m)
        4, 6, 9, 11: return 30;
        2: return 28;
        default: return 31;
      endcase
    endfunction

    function date_diff_t predict_difference(date_pair_t p);
      int sy, sm, sd, ey, em, ed;
      int cmp, yrs, mons, dys, tot, bm, by;
      date_diff_t r;
      sy = (p.start_year > YEAR_LIMIT) ? YEAR_LIMIT : int'(p.start_year);
      ey = (p.end_year > YEAR_LIMIT) ? YEAR_LIMIT : int'(p.end_year);
      sm = p.start_month;
      em = p.end_month;
      sd = p.start_day;
      ed = p.end_day;
      if (ey != sy) cmp = ey - sy;
      else if (em != sm) cmp = em - sm;
      else cmp = ed - sd;
      r = '0;
      r.order = (cmp < 0) ? cdd_pkg::ORDER_BEFORE :
                (cmp == 0) ? cdd_pkg::ORDER_EQUAL : cdd_pkg::ORDER_AFTER;
      if (cmp >= 0) begin
        yrs  = ey - sy;
        mons = em - sm;
        dys  = ed - sd;
        if (dys < 0) begin
          // borrow the month before the end month, december wraps a year back
          bm = em - 1;
          by = ey;
          mons = mons - 1;
          if (bm < 1) begin
            bm = 12;
            by = by - 1;
          end
          dys = dys + month_length(by, bm);
        end
        if (mons < 0) begin
          yrs  = yrs - 1;
          mons = mons + 12;
        end
        tot = (ey - sy) * 12 + (em - sm);
        if (ed < sd) tot = tot - 1;
        if (tot < 0) tot = 0;
        if (tot > 131071) tot = 131071;
        r.elapsed_years  = yrs[cdd_pkg::YEAR_W-1:0];
        r.elapsed_months = mons[cdd_pkg::MONTH_W-1:0];
        r.elapsed_days   = dys[cdd_pkg::EDAY_W-1:0];
        r.total_months   = tot[cdd_pkg::TOTAL_W-1:0];
      end
      return r;
    endfunction

    function void note_pair(date_pair_t p);
      expected_diffs.push_back(predict_difference(p));
    endfunction

    function void check_diff(date_diff_t got);
      date_diff_t want;
      if (expected_diffs.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_diffs.pop_front();
      if (got.order !== want.order) begin
        $display("%0t order: expected %0d actual %0d", $time, want.order, got.order);
        errors++;
      end
      if (got.elapsed_years !== want.elapsed_years) begin
        $display("%0t elapsed_years: expected %0d actual %0d", $time,
                 want.elapsed_years, got.elapsed_years);
        errors++;
      end
      if (got.elapsed_months !== want.elapsed_months) begin
        $display("%0t elapsed_months: expected %0d actual %0d", $time,
                 want.elapsed_months, got.elapsed_months);
        errors++;
      end
      if (got.elapsed_days !== want.elapsed_days) begin
        $display("%0t elapsed_days: expected %0d actual %0d", $time,
                 $signed(want.elapsed_days), $signed(got.elapsed_days));
        errors++;
      end
      if (got.total_months !== want.total_months) begin
        $display("%0t total_months: expected %0d actual %0d", $time,
                 want.total_months, got.total_months);
        errors++;
      end
    endfunction

    function int pending();
      return expected_diffs.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  date_diff_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  int ready_hold  = 0;
  int cycle_count = 0;

  calendar_date_difference #(.MAX_YEAR(YEAR_LIMIT)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("calendar_date_difference verification failed");
      $finish;
    end
  end

  // receiver stalls in short bursts, none in the quiet tail
  always @(posedge clk) begin
    if (rst || quiet_phase) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_diff(date_diff_t'(m_tdata));
  end

  function automatic date_pair_t pack_dates(int sy, int sm, int sd, int ey, int em, int ed);
    date_pair_t p;
    p = '0;
    p.start_year  = sy[cdd_pkg::YEAR_W-1:0];
    p.start_month = sm[cdd_pkg::MONTH_W-1:0];
    p.start_day   = sd[cdd_pkg::DAY_W-1:0];
    p.end_year    = ey[cdd_pkg::YEAR_W-1:0];
    p.end_month   = em[cdd_pkg::MONTH_W-1:0];
    p.end_day     = ed[cdd_pkg::DAY_W-1:0];
    return p;
  endfunction

  task automatic send_pair(date_pair_t p);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    sb.note_pair(p);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_pair();
    int sy, sm, sd, ey, em, ed;
    if ($urandom_range(0, 4) == 0) begin
      // raw field values, out-of-range months, days and years included
      sy = $urandom_range(0, 16383);
      ey = ($urandom_range(0, 1) == 0) ? sy : $urandom_range(0, 16383);
      sm = $urandom_range(0, 15);
      em = $urandom_range(0, 15);
      sd = $urandom_range(0, 31);
      ed = $urandom_range(0, 31);
    end else begin
      sy = $urandom_range(1, 9999);
      case ($urandom_range(0, 3))
        0: ey = $urandom_range(1, 9999);
        1: ey = sy;
        2: ey = (sy < 9999) ? sy + 1 : sy;
        default: ey = (sy > 1) ? sy - 1 : sy;
      endcase
      sm = $urandom_range(1, 12);
      em = ($urandom_range(0, 3) == 0) ? sm : $urandom_range(1, 12);
      sd = $urandom_range(1, date_diff_scoreboard::month_length(sy, sm));
      ed = $urandom_range(1, date_diff_scoreboard::month_length(ey, em));
    end
    send_pair(pack_dates(sy, sm, sd, ey, em, ed));
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_pair(pack_dates(2024, 2, 29, 2024, 2, 29));     // equal dates
    send_pair(pack_dates(2000, 5, 10, 1999, 12, 31));    // end before start
    send_pair(pack_dates(2000, 5, 10, 2000, 5, 9));      // before by a day
    send_pair(pack_dates(2000, 1, 31, 2000, 3, 1));      // leap february borrow
    send_pair(pack_dates(2023, 1, 31, 2023, 3, 1));      // short borrow, negative days
    send_pair(pack_dates(2023, 1, 30, 2023, 3, 1));
    send_pair(pack_dates(1900, 1, 29, 1900, 3, 1));      // century, not leap
    send_pair(pack_dates(2020, 12, 15, 2021, 1, 10));    // december borrow
    send_pair(pack_dates(1, 1, 1, 9999, 12, 31));        // widest span
    send_pair(pack_dates(9999, 12, 31, 1, 1, 1));
    send_pair(pack_dates(16383, 15, 31, 16383, 15, 31)); // clamped years
    send_pair(pack_dates(12000, 3, 4, 9999, 3, 5));
    send_pair(pack_dates(0, 0, 0, 0, 0, 0));
    send_pair(pack_dates(2000, 15, 20, 2001, 0, 5));     // total clips at zero
    send_pair(pack_dates(2000, 1, 20, 2000, 15, 5));     // borrow from month 15
    send_pair(pack_dates(2000, 1, 20, 2000, 14, 5));
    send_pair(pack_dates(2000, 1, 20, 2000, 13, 5));
    send_pair(pack_dates(2000, 0, 31, 2000, 1, 0));      // day zero, month zero
    send_pair(pack_dates(5000, 6, 31, 5001, 7, 31));
    send_pair(pack_dates(8191, 8, 16, 8192, 7, 15));
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) wait_drained();
      if (i == QUIET_START) quiet_phase = 1'b1;
      send_random_pair();
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("calendar_date_difference verification clean");
    end else begin
      $display("calendar_date_difference verification failed");
    end
    $finish;
  end

endmodule
